// ----- sv/sktbs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the sorted key table with binary search.
// Used by the controller, the datapath and the top level.
package sktbs_pkg;

    localparam int KEY_W               = 24;
    localparam int TYPE_W              = 8;
    localparam int VAL_W               = 32;
    localparam int IDX_W               = 10;
    localparam int COUNT_W             = 11;
    localparam int ENTRY_W             = VAL_W + TYPE_W + KEY_W;
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    // Configuration register indexes
    localparam logic [0:0] REG_ENTRY_COUNT   = 1'b0;
    localparam logic [0:0] REG_BYTE_REVERSED = 1'b1;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_FIND  = 2'd1,
        REQ_FETCH = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FIND_INIT,
        ST_FIND,
        ST_FETCH,
        ST_FETCH_WAIT,
        ST_DROP,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // latch the accepted request
        logic load_write;  // write the normalized entry
        logic find_init;   // lo = 0, hi = count, first probe
        logic find_step;   // narrow the range, next probe
        logic fetch_read;  // read the entry at the request index
        logic res_miss;    // stage an all-zero result
        logic res_load;    // stage the loaded entry
        logic res_find;    // stage the probed entry
        logic res_fetch;   // stage the fetched entry
        logic emit;        // move the staged result to the output register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        req_t in_req;
        logic load_oob;
        logic fetch_oob;
        logic cnt_zero;
        logic key_eq;
        logic next_live;
        logic out_free;
    } dp_status_t;

endpackage

// ----- sv/sktbs_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module sktbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- sv/sktbs_ctrl.sv -----
`timescale 1ns / 1ps
// Request sequencer for the sorted key table: load, find and fetch flows.
// Depends on sktbs_pkg; drives the datapath through ctrl_cmd_t.
module sktbs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sktbs_pkg::dp_status_t  stat,
    output sktbs_pkg::ctrl_cmd_t   cmd
);

    import sktbs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (stat.in_req)
                        REQ_LOAD:  state_next = ST_LOAD;
                        REQ_FIND:  state_next = ST_FIND_INIT;
                        REQ_FETCH: state_next = ST_FETCH;
                        default:   state_next = ST_DROP;
                    endcase
                end
            end
            ST_LOAD:
            begin
                if (stat.load_oob)
                begin
                    cmd.res_miss = 1'b1;
                end
                else
                begin
                    cmd.load_write = 1'b1;
                    cmd.res_load   = 1'b1;
                end
                state_next = ST_EMIT;
            end
            ST_FIND_INIT:
            begin
                if (stat.cnt_zero)
                begin
                    cmd.res_miss = 1'b1;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    cmd.find_init = 1'b1;
                    state_next    = ST_FIND;
                end
            end
            ST_FIND:
            begin
                // one probe per cycle: compare, narrow, issue the next read
                if (stat.key_eq)
                begin
                    cmd.res_find = 1'b1;
                    state_next   = ST_EMIT;
                end
                else if (stat.next_live)
                begin
                    cmd.find_step = 1'b1;
                end
                else
                begin
                    cmd.res_miss = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_FETCH:
            begin
                if (stat.fetch_oob)
                begin
                    cmd.res_miss = 1'b1;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    cmd.fetch_read = 1'b1;
                    state_next     = ST_FETCH_WAIT;
                end
            end
            ST_FETCH_WAIT:
            begin
                cmd.res_fetch = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_DROP:
            begin
                cmd.res_miss = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output register is free
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/sktbs_dpath.sv -----
`timescale 1ns / 1ps
// Datapath for the sorted key table: config registers, request capture,
// binary search range registers, table RAM, result staging and output register.
// Depends on sktbs_pkg and sktbs_ram.
module sktbs_dpath #(
    parameter int TABLE_DEPTH = sktbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [0:0]                          cfg_index,
    input  logic [sktbs_pkg::COUNT_W-1:0]       cfg_data,
    input  logic [1:0]                          req_type,
    input  logic [sktbs_pkg::IDX_W-1:0]         index,
    input  logic [sktbs_pkg::VAL_W-1:0]         pair_word,
    input  logic [sktbs_pkg::VAL_W-1:0]         value_word,
    input  logic [sktbs_pkg::KEY_W-1:0]         search_key,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic [sktbs_pkg::IDX_W-1:0]         entry_index,
    output logic [sktbs_pkg::TYPE_W-1:0]        data_type,
    output logic [sktbs_pkg::VAL_W-1:0]         data_value,
    input  sktbs_pkg::ctrl_cmd_t                cmd,
    output sktbs_pkg::dp_status_t               stat
);

    import sktbs_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    function automatic logic [KEY_W-1:0] swap24(input logic [KEY_W-1:0] x);
        return {x[7:0], x[15:8], x[23:16]};
    endfunction

    function automatic logic [VAL_W-1:0] swap32(input logic [VAL_W-1:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // Configuration
    logic [COUNT_W-1:0] entry_count_reg;
    logic               byte_reversed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg   <= '0;
            byte_reversed_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ENTRY_COUNT:   entry_count_reg   <= cfg_data;
                REG_BYTE_REVERSED: byte_reversed_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Effective count, saturated at the table depth
    logic [COUNT_W-1:0] cnt;
    always_comb
    begin
        if ({{(32-COUNT_W){1'b0}}, entry_count_reg} > 32'(TABLE_DEPTH))
        begin
            cnt = COUNT_W'(TABLE_DEPTH);
        end
        else
        begin
            cnt = entry_count_reg;
        end
    end

    // Request capture; load words are normalized here
    logic [IDX_W-1:0]  idx_reg;
    logic [KEY_W-1:0]  skey_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TYPE_W-1:0] type_reg;
    logic [VAL_W-1:0]  val_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg  <= index;
            skey_reg <= search_key;
            type_reg <= pair_word[VAL_W-1:KEY_W];
            key_reg  <= byte_reversed_reg ? swap24(pair_word[KEY_W-1:0])
                                          : pair_word[KEY_W-1:0];
            val_reg  <= byte_reversed_reg ? swap32(value_word) : value_word;
        end
    end

    // Table RAM
    logic [ENTRY_W-1:0] rdata;
    logic [IDX_W-1:0]   addr_sel;
    logic [ADDR_W+IDX_W-1:0] addr_wide;
    logic [ADDR_W-1:0]  ram_addr;

    // Binary search range
    logic [COUNT_W-1:0] lo_reg;
    logic [COUNT_W-1:0] hi_reg;
    logic [IDX_W-1:0]   mid_reg;
    logic [COUNT_W-1:0] lo_next;
    logic [COUNT_W-1:0] hi_next;
    logic [COUNT_W-1:0] mid_sum;
    logic [IDX_W-1:0]   mid_next;
    logic [KEY_W-1:0]   probe_key;
    logic               key_gt;

    assign probe_key = rdata[KEY_W-1:0];
    assign key_gt    = skey_reg > probe_key;
    assign lo_next   = key_gt ? ({1'b0, mid_reg} + COUNT_W'(1)) : lo_reg;
    assign hi_next   = key_gt ? hi_reg : {1'b0, mid_reg};
    assign mid_sum   = lo_next + hi_next;
    assign mid_next  = mid_sum[COUNT_W-1:1];

    always_ff @(posedge clk)
    begin
        if (cmd.find_init)
        begin
            lo_reg  <= '0;
            hi_reg  <= cnt;
            mid_reg <= cnt[COUNT_W-1:1];
        end
        else if (cmd.find_step)
        begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            mid_reg <= mid_next;
        end
    end

    always_comb
    begin
        if (cmd.find_init)
        begin
            addr_sel = cnt[COUNT_W-1:1];
        end
        else if (cmd.find_step)
        begin
            addr_sel = mid_next;
        end
        else if (cmd.load_write || cmd.fetch_read)
        begin
            addr_sel = idx_reg;
        end
        else
        begin
            addr_sel = mid_reg;
        end
    end

    // widen or trim the table index to the RAM address width
    assign addr_wide = {{ADDR_W{1'b0}}, addr_sel};
    assign ram_addr  = addr_wide[ADDR_W-1:0];

    sktbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.load_write),
        .addr  (ram_addr),
        .wdata ({val_reg, type_reg, key_reg}),
        .rdata (rdata)
    );

    // Result staging
    logic               res_hit_reg;
    logic [IDX_W-1:0]   res_idx_reg;
    logic [TYPE_W-1:0]  res_type_reg;
    logic [VAL_W-1:0]   res_val_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.res_miss)
        begin
            res_hit_reg  <= 1'b0;
            res_idx_reg  <= '0;
            res_type_reg <= '0;
            res_val_reg  <= '0;
        end
        else if (cmd.res_load)
        begin
            res_hit_reg  <= 1'b1;
            res_idx_reg  <= idx_reg;
            res_type_reg <= type_reg;
            res_val_reg  <= val_reg;
        end
        else if (cmd.res_find || cmd.res_fetch)
        begin
            res_hit_reg  <= 1'b1;
            res_idx_reg  <= cmd.res_find ? mid_reg : idx_reg;
            res_type_reg <= rdata[KEY_W+TYPE_W-1:KEY_W];
            res_val_reg  <= rdata[ENTRY_W-1:KEY_W+TYPE_W];
        end
    end

    // Output register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            hit         <= res_hit_reg;
            entry_index <= res_idx_reg;
            data_type   <= res_type_reg;
            data_value  <= res_val_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // Status
    assign stat.in_req    = req_t'(req_type);
    assign stat.load_oob  = 32'(idx_reg) >= 32'(TABLE_DEPTH);
    assign stat.fetch_oob = {1'b0, idx_reg} >= cnt;
    assign stat.cnt_zero  = cnt == '0;
    assign stat.key_eq    = skey_reg == probe_key;
    assign stat.next_live = lo_next < hi_next;
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule

// ----- sv/sorted_key_table_binary_search.sv -----
`timescale 1ns / 1ps
// Sorted key table with binary search: top level joining controller and datapath.
// Depends on sktbs_pkg, sktbs_ctrl, sktbs_dpath (and sktbs_ram below it).
//
//   channel  signals                                         handshake
//   -------  ----------------------------------------------  -------------------
//   in       req_type index pair_word value_word search_key  in_valid / in_ready
//   out      hit entry_index data_type data_value            out_valid / out_ready
//   cfg      cfg_index cfg_data                              cfg_write (no wait)
//
// Load: ST_LOAD, ST_EMIT. Fetch: ST_FETCH, ST_FETCH_WAIT, ST_EMIT. Find: P probes of
// the table RAM in ST_FIND after ST_FIND_INIT (at most 11 for 1024 entries, one per
// cycle behind the registered read), then ST_EMIT. Empty-table finds, out-of-range
// fetches and unknown requests (ST_DROP) skip to ST_EMIT. One request is in flight;
// the next is taken in the cycle after the emit, while the last result waits.
// Reset clears config and control; table contents stay undefined until loaded.
module sorted_key_table_binary_search #(
    parameter int TABLE_DEPTH = sktbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [0:0]                     cfg_index,
    input  logic [sktbs_pkg::COUNT_W-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     req_type,
    input  logic [sktbs_pkg::IDX_W-1:0]    index,
    input  logic [sktbs_pkg::VAL_W-1:0]    pair_word,
    input  logic [sktbs_pkg::VAL_W-1:0]    value_word,
    input  logic [sktbs_pkg::KEY_W-1:0]    search_key,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           hit,
    output logic [sktbs_pkg::IDX_W-1:0]    entry_index,
    output logic [sktbs_pkg::TYPE_W-1:0]   data_type,
    output logic [sktbs_pkg::VAL_W-1:0]    data_value
);

    import sktbs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    sktbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sktbs_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (req_type),
        .index       (index),
        .pair_word   (pair_word),
        .value_word  (value_word),
        .search_key  (search_key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .entry_index (entry_index),
        .data_type   (data_type),
        .data_value  (data_value),
        .cmd         (cmd),
        .stat        (stat)
    );

    // A miss carries an all-zero payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> entry_index == '0 && data_type == '0 && data_value == '0)
        else $error("miss result with nonzero payload");

    // A hit always names an entry inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> 32'(entry_index) < 32'(TABLE_DEPTH))
        else $error("hit index beyond table depth");

    // After a transfer in, in_ready is low in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a request is in flight");

    // A new result never lands on one that was not yet taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_value) && $stable(hit))
        else $error("pending result overwritten");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sorted_key_table_binary_search: loads sorted tables,
// drives find, fetch, load and unknown traffic and checks every answer in order.
// Depends on sktbs_pkg and the sorted_key_table_binary_search RTL.
module tb;
    import sktbs_pkg::*;

    localparam int DEPTH       = DEFAULT_TABLE_DEPTH;
    localparam int LONG_STALL  = 300;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SHOW_MAX    = 10;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [1:0]       req;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] pw;
        logic [VAL_W-1:0] vw;
        logic [KEY_W-1:0] skey;
    } lookup_t;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  idx;
        logic [TYPE_W-1:0] dtype;
        logic [VAL_W-1:0]  dval;
    } answer_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               cfg_write  = 1'b0;
    logic [0:0]         cfg_index  = '0;
    logic [COUNT_W-1:0] cfg_data   = '0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic [1:0]         req_type   = '0;
    logic [IDX_W-1:0]   index      = '0;
    logic [VAL_W-1:0]   pair_word  = '0;
    logic [VAL_W-1:0]   value_word = '0;
    logic [KEY_W-1:0]   search_key = '0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic               hit;
    logic [IDX_W-1:0]   entry_index;
    logic [TYPE_W-1:0]  data_type;
    logic [VAL_W-1:0]   data_value;

    // table model, updated in transfer order
    logic [KEY_W-1:0]   tbl_key  [DEPTH];
    logic [TYPE_W-1:0]  tbl_type [DEPTH];
    logic [VAL_W-1:0]   tbl_val  [DEPTH];
    logic [COUNT_W-1:0] model_count = '0;
    logic               model_rev   = 1'b0;

    // keys as the stimulus side expects them to land, updated when queued
    logic [KEY_W-1:0]   shadow_key [DEPTH];

    lookup_t     lookup_queue[$];
    answer_t     due_answers[$];
    lookup_t     offer;
    answer_t     due_now;
    answer_t     got;
    logic        in_took = 1'b0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        stall_req  = 1'b0;
    int unsigned stall_left = 0;
    int unsigned cycles     = 0;
    int unsigned n_queued   = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked  = 0;
    int unsigned n_bad      = 0;
    int unsigned n_load     = 0;
    int unsigned n_find     = 0;
    int unsigned n_find_hit = 0;
    int unsigned n_fetch    = 0;
    int unsigned n_unknown  = 0;

    sorted_key_table_binary_search DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .index       (index),
        .pair_word   (pair_word),
        .value_word  (value_word),
        .search_key  (search_key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .entry_index (entry_index),
        .data_type   (data_type),
        .data_value  (data_value)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [KEY_W-1:0] swap24(input logic [KEY_W-1:0] k);
        return {k[7:0], k[15:8], k[23:16]};
    endfunction

    // Apply one request to the table model and return the answer it must produce.
    function automatic answer_t table_answer(input lookup_t r);
        answer_t          a;
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
        int unsigned      lo, hi, mid, live;
        logic             found;
        a = '0;
        found = 1'b0;
        live = (model_count > DEPTH) ? DEPTH : model_count;
        case (r.req)
            REQ_LOAD:
            begin
                k = model_rev ? swap24(r.pw[KEY_W-1:0]) : r.pw[KEY_W-1:0];
                v = model_rev ? {r.vw[7:0], r.vw[15:8], r.vw[23:16], r.vw[31:24]} : r.vw;
                tbl_key[r.idx]  = k;
                tbl_type[r.idx] = r.pw[31:24];
                tbl_val[r.idx]  = v;
                a = '{1'b1, r.idx, r.pw[31:24], v};
            end
            REQ_FIND:
            begin
                lo = 0;
                hi = live;
                while (lo < hi && !found)
                begin
                    mid = (lo + hi) / 2;
                    if (tbl_key[mid] == r.skey)
                    begin
                        found = 1'b1;
                        a = '{1'b1, mid[IDX_W-1:0], tbl_type[mid], tbl_val[mid]};
                    end
                    else if (r.skey > tbl_key[mid])
                        lo = mid + 1;
                    else
                        hi = mid;
                end
            end
            REQ_FETCH:
            begin
                if (r.idx < live)
                    a = '{1'b1, r.idx, tbl_type[r.idx], tbl_val[r.idx]};
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic note_mismatch(input string what, input answer_t exp, input answer_t act);
        n_bad++;
        if (n_bad <= SHOW_MAX)
            $display({"%0t: %s: expected hit=%0d idx=%0d type=%02h value=%08h,",
                      " got hit=%0d idx=%0d type=%02h value=%08h"},
                     $time, what, exp.hit, exp.idx, exp.dtype, exp.dval,
                     act.hit, act.idx, act.dtype, act.dval);
    endtask

    // input side: offer the next request once the previous one transferred
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (lookup_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                offer = lookup_queue.pop_front();
                req_type   <= offer.req;
                index      <= offer.idx;
                pair_word  <= offer.pw;
                value_word <= offer.vw;
                search_key <= offer.skey;
                in_valid   <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        in_took <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            due_now = table_answer(offer);
            due_answers.push_back(due_now);
            n_accepted++;
            case (offer.req)
                REQ_LOAD:  n_load++;
                REQ_FIND:
                begin
                    n_find++;
                    if (due_now.hit)
                        n_find_hit++;
                end
                REQ_FETCH: n_fetch++;
                default:   n_unknown++;
            endcase
        end
    end

    // output side
    always @(negedge clk)
        out_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (stall_req)
            stall_left <= LONG_STALL;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got = '{hit, entry_index, data_type, data_value};
            n_checked++;
            if (due_answers.size() == 0)
                note_mismatch("answer with nothing due", '0, got);
            else
            begin
                due_now = due_answers.pop_front();
                if (got.hit !== due_now.hit || got.idx !== due_now.idx ||
                    got.dtype !== due_now.dtype || got.dval !== due_now.dval)
                    note_mismatch("answer mismatch", due_now, got);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d answers still due", $time, due_answers.size());
            $display("** sorted_key_table_binary_search: FAILED **");
            $finish;
        end
    end

    task automatic push_item(input logic [1:0] req, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] pw, input logic [VAL_W-1:0] vw,
                             input logic [KEY_W-1:0] skey);
        lookup_t it;
        it = '{req, idx, pw, vw, skey};
        if (req == REQ_LOAD)
            shadow_key[idx] = model_rev ? swap24(pw[KEY_W-1:0]) : pw[KEY_W-1:0];
        lookup_queue.push_back(it);
        n_queued++;
    endtask

    // Hold until every queued request has transferred and been answered.
    task automatic drain();
        while (!(n_accepted == n_queued && due_answers.size() == 0))
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] which, input logic [COUNT_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= which;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (which == REG_ENTRY_COUNT)
            model_count = val;
        else
            model_rev = val[0];
    endtask

    // Load entries 0..n-1 with ascending keys (duplicates now and then).
    task automatic fill_sorted(input int unsigned n);
        int unsigned       k, span, step;
        logic [IDX_W-1:0]  at;
        logic [TYPE_W-1:0] ty;
        logic [KEY_W-1:0]  kk;
        k = $urandom_range(255);
        span = 32'hFFFFFF / n;
        for (int unsigned i = 0; i < n; i++)
        begin
            at = IDX_W'(i);
            ty = TYPE_W'($urandom);
            kk = KEY_W'(k);
            push_item(REQ_LOAD, at, {ty, model_rev ? swap24(kk) : kk}, $urandom,
                      KEY_W'($urandom));
            step = ($urandom_range(9) == 0) ? 0 : $urandom_range(span, 1);
            if (k + step <= 32'hFFFFFF)
                k = k + step;
        end
    endtask

    task automatic add_mixed(input int unsigned n);
        int unsigned      live, pick;
        logic [IDX_W-1:0] at;
        logic [KEY_W-1:0] key;
        live = (model_count > DEPTH) ? DEPTH : model_count;
        repeat (n)
        begin
            pick = $urandom_range(99);
            at   = IDX_W'($urandom);
            key  = KEY_W'($urandom);
            if (pick < 60)
            begin
                if (live != 0 && pick < 45)
                    key = shadow_key[$urandom_range(live - 1)];
                else if (live != 0 && pick < 52)
                    key = shadow_key[$urandom_range(live - 1)] + 1'b1;
                push_item(REQ_FIND, at, $urandom, $urandom, key);
            end
            else if (pick < 82)
            begin
                if (live != 0 && pick < 76)
                    at = IDX_W'($urandom_range(live - 1));
                push_item(REQ_FETCH, at, $urandom, $urandom, key);
            end
            else if (pick < 91)
            begin
                // while not full, most overwrites go outside the searched range to keep keys sorted
                if (live < DEPTH && pick < 89)
                    at = IDX_W'($urandom_range(DEPTH - 1, live));
                push_item(REQ_LOAD, at, $urandom, $urandom, key);
            end
            else
                push_item(REQ_UNKNOWN, at, $urandom, $urandom, key);
        end
    endtask

    initial
    begin
        int unsigned c;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(REG_ENTRY_COUNT, '0);
        write_reg(REG_BYTE_REVERSED, 11'd0);

        // empty table: finds, fetches and the unknown request miss; loads still land
        push_item(REQ_FIND, '0, '0, '0, '0);
        push_item(REQ_FIND, '1, '1, '1, '1);
        push_item(REQ_FETCH, '0, '0, '0, '0);
        push_item(REQ_FETCH, '1, '1, '1, '1);
        push_item(REQ_UNKNOWN, '1, '1, '1, '1);
        push_item(REQ_LOAD, 10'd0, 32'h0000_0000, 32'h0000_0000, '1);
        push_item(REQ_LOAD, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
        push_item(REQ_LOAD, 10'd1, 32'h7F00_0010, 32'h1234_5678, '0);
        drain();
        write_reg(REG_BYTE_REVERSED, 11'd1);
        push_item(REQ_LOAD, 10'd2, {8'hA5, swap24(24'h000020)}, 32'h0102_0304, '0);
        push_item(REQ_LOAD, 10'd3, {8'h5A, swap24(24'hFFFFFF)}, 32'hDEAD_BEEF, '0);
        drain();
        write_reg(REG_ENTRY_COUNT, 11'd4);
        push_item(REQ_FIND, '1, '0, '0, 24'h000000);
        push_item(REQ_FIND, '0, '1, '1, 24'h000010);
        push_item(REQ_FIND, '0, '0, '0, 24'h000020);
        push_item(REQ_FIND, '0, '0, '0, 24'hFFFFFF);
        push_item(REQ_FIND, '0, '0, '0, 24'h000015);
        push_item(REQ_FETCH, 10'd3, '0, '0, '0);
        push_item(REQ_FETCH, 10'd4, '0, '0, '0);
        push_item(REQ_FETCH, 10'd1023, '0, '0, '0);
        // duplicate keys: the first probe that matches wins
        for (int i = 0; i < 4; i++)
            push_item(REQ_LOAD, IDX_W'(i), {8'(i + 1), swap24(24'h000007)}, $urandom, '0);
        push_item(REQ_FIND, '0, '0, '0, 24'h000007);
        drain();

        // full table, count above the depth, long output stall with a steady sender
        write_reg(REG_BYTE_REVERSED, 11'd0);
        fill_sorted(DEPTH);
        drain();
        write_reg(REG_ENTRY_COUNT, 11'd2047);
        stall_req = 1'b1;
        while (stall_left == 0)
            @(posedge clk);
        stall_req = 1'b0;
        add_mixed(120);
        drain();

        send_idle_pct  = 81;
        recv_stall_pct = 0;
        write_reg(REG_BYTE_REVERSED, 11'd1);
        c = $urandom_range(64, 16);
        fill_sorted(c);
        drain();
        write_reg(REG_ENTRY_COUNT, COUNT_W'(c));
        add_mixed(120);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 81;
        write_reg(REG_BYTE_REVERSED, 11'd0);
        fill_sorted(1);
        drain();
        write_reg(REG_ENTRY_COUNT, 11'd1);
        add_mixed(60);
        drain();

        send_idle_pct  = 29;
        recv_stall_pct = 29;
        write_reg(REG_BYTE_REVERSED, 11'd1);
        c = $urandom_range(200, 100);
        fill_sorted(c);
        drain();
        write_reg(REG_ENTRY_COUNT, COUNT_W'(c));
        add_mixed(120);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(REG_BYTE_REVERSED, COUNT_W'($urandom_range(1)));
        write_reg(REG_ENTRY_COUNT, 11'd1024);
        add_mixed(80);
        drain();
        write_reg(REG_ENTRY_COUNT, '0);
        add_mixed(20);
        drain();

        $display("Covered %0d loads, %0d finds (%0d hits), %0d fetches, %0d unknown requests;",
                 n_load, n_find, n_find_hit, n_fetch, n_unknown);
        $display("counts 0 to 2047, both byte orders, four idle mixes, %0d answers checked.",
                 n_checked);
        if (n_bad == 0 && due_answers.size() == 0)
            $display("** sorted_key_table_binary_search: PASSED **");
        else
            $display("** sorted_key_table_binary_search: FAILED **");
        $finish;
    end

endmodule
